// ===== rtl/rjf_pkg.sv =====
`timescale 1ns / 1ps

package rjf_pkg;

    // Fixed field widths of the channels
    localparam int COORD_W  = 16;
    localparam int AREA_W   = 2 * (COORD_W + 1);
    localparam int SUM_W    = 48;
    localparam int COUNT_W  = 16;
    localparam int THR_W    = 31;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Divisor of the relative overhead test
    localparam int DIV_CONST = 100;

    // Configuration space
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_JOIN_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        KIND_FILLER    = 2'd0,
        KIND_SUMMARY   = 2'd1,
        KIND_ORDER_ERR = 2'd2
    } kind_t;

    // Rectangle after the front: masked edges plus its own area
    typedef struct packed {
        logic [COORD_W-1:0]       left;
        logic [COORD_W-1:0]       top;
        logic [COORD_W-1:0]       right;
        logic [COORD_W-1:0]       bottom;
        logic                     first_rect;
        logic                     last_rect;
        logic signed [AREA_W-1:0] area;
    } rect_rec_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] out_left;
        logic [COORD_W-1:0] out_top;
        logic [COORD_W-1:0] out_right;
        logic [COORD_W-1:0] out_bottom;
        logic [SUM_W-1:0]   overhead_total;
        logic [COUNT_W-1:0] joins_done;
        logic               run_end;
    } result_t;

endpackage

// ===== rtl/rjf_in_if.sv =====
`timescale 1ns / 1ps

interface rjf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic        first_rect;
    logic        last_rect;

    modport source (
        output valid, left, top, right, bottom, first_rect, last_rect,
        input  ready
    );
    modport sink (
        input  valid, left, top, right, bottom, first_rect, last_rect,
        output ready
    );
endinterface

// ===== rtl/rjf_out_if.sv =====
`timescale 1ns / 1ps

interface rjf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_right;
    logic [15:0] out_bottom;
    logic [47:0] overhead_total;
    logic [15:0] joins_done;
    logic        run_end;

    modport source (
        output valid, kind, out_left, out_top, out_right, out_bottom,
               overhead_total, joins_done, run_end,
        input  ready
    );
    modport sink (
        input  valid, kind, out_left, out_top, out_right, out_bottom,
               overhead_total, joins_done, run_end,
        output ready
    );
endinterface

// ===== rtl/rect_join_filler_unit.sv =====
`timescale 1ns / 1ps

// Rectangle join filler.
// rect (sink): one rectangle per transaction, in band order, with first_rect
// and last_rect marking the region boundaries.
// result (source): filler rectangles, order errors and end-of-region
// summaries; run_end marks the last result of a rectangle.
// APB port: join_threshold at byte address 0, written at the access cycle,
// readable; pready is always high.
// A rectangle passes the front register, the queue and the result register
// before its first result shows on the result port.
// Throughput: one rectangle per cycle while each gives at most one result
// and the receiver is ready; a rectangle with a join and a summary fills both
// result slots; the next waits until the second leaves. The back loop (one
// multiply, add and compare on the previous rectangle) sets this rate.
// Reset clears the previous rectangle, totals, abort flag, queue and
// threshold. When the receiver stalls, results wait in a two-entry result
// stage and rectangles collect in the four-entry queue and front register
// before rect.ready drops.
module rect_join_filler_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rjf_in_if.sink                            rect,
    rjf_out_if.source                         result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rjf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rjf_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rjf_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    localparam int TW = rjf_pkg::THR_W;
    localparam int DW = rjf_pkg::CFG_DATA_W;

    logic [TW-1:0]      thr_reg, thr_next;
    logic               cfg_wr, sel_thr;
    logic               push, full, pop, head_valid;
    rjf_pkg::rect_rec_t push_data, head;

    // Configuration register
    assign pready  = 1'b1;
    assign sel_thr = (paddr[rjf_pkg::CFG_ADDR_W-1:2] == rjf_pkg::REG_JOIN_THRESHOLD);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_wr && sel_thr)
        begin
            thr_next = pwdata[TW-1:0];
        end
        prdata = sel_thr ? DW'(thr_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    rjf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rect       (rect),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    rjf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    rjf_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop),
        .join_threshold (thr_reg),
        .result         (result)
    );

endmodule

// ===== rtl/rjf_front.sv =====
`timescale 1ns / 1ps

module rjf_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    rjf_in_if.sink              rect,
    output logic                push,
    output rjf_pkg::rect_rec_t  push_data,
    input  logic                full
);
    localparam int CW = rjf_pkg::COORD_W;
    localparam int AW = rjf_pkg::AREA_W;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic                     valid_reg;
    logic                     valid_next;
    rjf_pkg::rect_rec_t       rec_reg;
    logic                     accept;
    logic [COORD_BITS-1:0]    cl, ct, cr, cb;
    logic signed [DW-1:0]     width, height;
    logic signed [PW-1:0]     area;

    // Mask edges to the coordinate range and take the rectangle's own area
    always_comb
    begin
        cl     = rect.left[COORD_BITS-1:0];
        ct     = rect.top[COORD_BITS-1:0];
        cr     = rect.right[COORD_BITS-1:0];
        cb     = rect.bottom[COORD_BITS-1:0];
        width  = $signed({1'b0, cr}) - $signed({1'b0, cl});
        height = $signed({1'b0, cb}) - $signed({1'b0, ct});
        area   = width * height;
    end

    assign push       = valid_reg && !full;
    assign rect.ready = !valid_reg || !full;
    assign accept     = rect.valid && rect.ready;
    assign push_data  = rec_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload stage, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rec_reg.left       <= CW'(cl);
            rec_reg.top        <= CW'(ct);
            rec_reg.right      <= CW'(cr);
            rec_reg.bottom     <= CW'(cb);
            rec_reg.first_rect <= rect.first_rect;
            rec_reg.last_rect  <= rect.last_rect;
            rec_reg.area       <= AW'(area);
        end
    end

endmodule

// ===== rtl/rjf_queue.sv =====
`timescale 1ns / 1ps

module rjf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rjf_pkg::rect_rec_t  push_data,
    output logic                full,
    input  logic                pop,
    output rjf_pkg::rect_rec_t  head,
    output logic                head_valid
);
    localparam int DEPTH = rjf_pkg::QUEUE_DEPTH;
    localparam int PW    = rjf_pkg::QUEUE_PTR_W;
    localparam int NW    = rjf_pkg::QUEUE_CNT_W;

    rjf_pkg::rect_rec_t mem [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]      count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == NW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/rjf_back.sv =====
`timescale 1ns / 1ps

module rjf_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rjf_pkg::rect_rec_t         head,
    input  logic                       head_valid,
    output logic                       pop,
    input  logic [rjf_pkg::THR_W-1:0]  join_threshold,
    rjf_out_if.source                  result
);
    localparam int CW   = rjf_pkg::COORD_W;
    localparam int SUMW = rjf_pkg::SUM_W;
    localparam int NW   = rjf_pkg::COUNT_W;
    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int OVW  = PW + 2;
    localparam int CMPW = (OVW > 32) ? OVW : 32;
    localparam int HW   = OVW + 8;
    localparam int TW   = SUMW + 2;

    // Previous rectangle, its area and the region totals
    logic [COORD_BITS-1:0] pl_reg, pt_reg, pr_reg, pb_reg;
    logic [COORD_BITS-1:0] pl_next, pt_next, pr_next, pb_next;
    logic signed [PW-1:0]  parea_reg, parea_next;
    logic [SUMW-1:0]       sum_reg, sum_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic                  aborted_reg, aborted_next;

    // Two result slots: A drives the port, B holds a second result
    rjf_pkg::result_t      a_reg, a_next, b_reg, b_next;
    logic                  a_valid_reg, a_valid_next;
    logic                  b_valid_reg, b_valid_next;

    logic                  do_pop;
    logic [COORD_BITS-1:0] cl, ct, cr, cb;
    logic [COORD_BITS-1:0] bl, bt, br, bb;
    logic                  same_band, order_err;
    logic signed [DW-1:0]  mul_x, mul_y;
    logic signed [PW-1:0]  prod, a2;
    logic signed [SW-1:0]  s_sum;
    logic signed [OVW-1:0] ov;
    logic signed [CMPW-1:0] ov_c, thr_c;
    logic signed [HW-1:0]  hv, s_h;
    logic                  below_thr, rel_small;
    logic signed [TW-1:0]  t_sum;
    logic [SUMW-1:0]       sum_join;
    logic [NW-1:0]         cnt_join;
    logic                  take_join, is_box, err, skip, upd_prev, emit_sum;
    logic [SUMW-1:0]       sum_after;
    logic [NW-1:0]         cnt_after;
    rjf_pkg::result_t      fill_res, sum_res, err_res, r0, r1;
    logic                  r0_valid, r1_valid;

    assign do_pop = head_valid && !b_valid_reg && (!a_valid_reg || result.ready);
    assign pop    = do_pop;

    // Edges, band test and bounding box
    always_comb
    begin
        cl        = head.left[COORD_BITS-1:0];
        ct        = head.top[COORD_BITS-1:0];
        cr        = head.right[COORD_BITS-1:0];
        cb        = head.bottom[COORD_BITS-1:0];
        same_band = (ct == pt_reg) && (cb == pb_reg);
        order_err = (pr_reg > cl);
        bl        = (pl_reg < cl) ? pl_reg : cl;
        br        = (pr_reg > cr) ? pr_reg : cr;
        bt        = (pt_reg < ct) ? pt_reg : ct;
        bb        = (pb_reg > cb) ? pb_reg : cb;
    end

    // One shared multiplier: gap area in a band, box area across bands.
    // In the same band the box height equals the band height.
    always_comb
    begin
        if (same_band)
        begin
            mul_x = $signed({1'b0, cl}) - $signed({1'b0, pr_reg});
        end
        else
        begin
            mul_x = $signed({1'b0, br}) - $signed({1'b0, bl});
        end
        mul_y = $signed({1'b0, bb}) - $signed({1'b0, bt});
        prod  = mul_x * mul_y;
        a2    = $signed(head.area[PW-1:0]);
        s_sum = SW'(parea_reg) + SW'(a2);
        if (same_band)
        begin
            ov = OVW'(prod);
        end
        else
        begin
            ov = OVW'(prod) - OVW'(s_sum);
        end
    end

    // Join tests. ov < trunc(S / 100) is rewritten without a divider:
    // S >= 0: 100 * ov + 100 <= S;  S < 0: 100 * ov < S.
    always_comb
    begin
        ov_c      = CMPW'(ov);
        thr_c     = $signed(CMPW'({1'b0, join_threshold}));
        below_thr = (ov_c < thr_c);
        hv        = (HW'(ov) <<< 6) + (HW'(ov) <<< 5) + (HW'(ov) <<< 2);
        s_h       = HW'(s_sum);
        if (s_sum[SW-1])
        begin
            rel_small = (hv < s_h);
        end
        else
        begin
            rel_small = ((hv + HW'(rjf_pkg::DIV_CONST)) <= s_h);
        end
    end

    // Saturating totals after a join
    always_comb
    begin
        t_sum = $signed({2'b00, sum_reg}) + TW'(ov);
        if (t_sum[TW-1])
        begin
            sum_join = '0;
        end
        else if (t_sum[TW-2:SUMW] != '0)
        begin
            sum_join = '1;
        end
        else
        begin
            sum_join = t_sum[SUMW-1:0];
        end
        cnt_join = (cnt_reg == '1) ? cnt_reg : cnt_reg + NW'(1);
    end

    // Classify the transaction and form its results
    always_comb
    begin
        take_join = 1'b0;
        is_box    = 1'b0;
        err       = 1'b0;
        skip      = 1'b0;
        upd_prev  = 1'b0;
        if (head.first_rect)
        begin
            upd_prev = 1'b1;
        end
        else if (aborted_reg)
        begin
            skip = 1'b1;
        end
        else if (same_band)
        begin
            if (order_err)
            begin
                err = 1'b1;
            end
            else
            begin
                upd_prev  = 1'b1;
                take_join = below_thr;
            end
        end
        else
        begin
            upd_prev  = 1'b1;
            take_join = below_thr || rel_small;
            is_box    = take_join;
        end
        emit_sum = head.last_rect && !skip && !err;

        if (take_join)
        begin
            sum_after = sum_join;
            cnt_after = cnt_join;
        end
        else if (head.first_rect)
        begin
            sum_after = '0;
            cnt_after = '0;
        end
        else
        begin
            sum_after = sum_reg;
            cnt_after = cnt_reg;
        end

        fill_res                = '0;
        fill_res.kind           = rjf_pkg::KIND_FILLER;
        fill_res.run_end        = !emit_sum;
        if (same_band)
        begin
            fill_res.out_left   = CW'(pr_reg);
            fill_res.out_top    = CW'(pt_reg);
            fill_res.out_right  = CW'(cl);
            fill_res.out_bottom = CW'(pb_reg);
        end
        else
        begin
            fill_res.out_left   = CW'(bl);
            fill_res.out_top    = CW'(bt);
            fill_res.out_right  = CW'(br);
            fill_res.out_bottom = CW'(bb);
        end

        sum_res                = '0;
        sum_res.kind           = rjf_pkg::KIND_SUMMARY;
        sum_res.overhead_total = sum_after;
        sum_res.joins_done     = cnt_after;
        sum_res.run_end        = 1'b1;

        err_res         = '0;
        err_res.kind    = rjf_pkg::KIND_ORDER_ERR;
        err_res.run_end = 1'b1;

        if (err)
        begin
            r0       = err_res;
            r0_valid = 1'b1;
            r1       = sum_res;
            r1_valid = 1'b0;
        end
        else
        begin
            r0       = take_join ? fill_res : sum_res;
            r0_valid = take_join || emit_sum;
            r1       = sum_res;
            r1_valid = take_join && emit_sum;
        end
    end

    // Next state of the previous rectangle, totals and result slots
    always_comb
    begin
        pl_next      = pl_reg;
        pt_next      = pt_reg;
        pr_next      = pr_reg;
        pb_next      = pb_reg;
        parea_next   = parea_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        aborted_next = aborted_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;

        if (do_pop)
        begin
            sum_next = sum_after;
            cnt_next = cnt_after;
            if (head.first_rect)
            begin
                aborted_next = 1'b0;
            end
            else if (err)
            begin
                aborted_next = 1'b1;
            end
            if (upd_prev)
            begin
                if (is_box)
                begin
                    pl_next    = bl;
                    pt_next    = bt;
                    pr_next    = br;
                    pb_next    = bb;
                    parea_next = prod;
                end
                else
                begin
                    pl_next    = cl;
                    pt_next    = ct;
                    pr_next    = cr;
                    pb_next    = cb;
                    parea_next = a2;
                end
            end
            a_next       = r0;
            a_valid_next = r0_valid;
            b_next       = r1;
            b_valid_next = r1_valid;
        end
        else if (a_valid_reg && result.ready)
        begin
            a_next       = b_reg;
            a_valid_next = b_valid_reg;
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_reg      <= '0;
            pt_reg      <= '0;
            pr_reg      <= '0;
            pb_reg      <= '0;
            parea_reg   <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            aborted_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            pl_reg      <= pl_next;
            pt_reg      <= pt_next;
            pr_reg      <= pr_next;
            pb_reg      <= pb_next;
            parea_reg   <= parea_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            aborted_reg <= aborted_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign result.valid          = a_valid_reg;
    assign result.kind           = a_reg.kind;
    assign result.out_left       = a_reg.out_left;
    assign result.out_top        = a_reg.out_top;
    assign result.out_right      = a_reg.out_right;
    assign result.out_bottom     = a_reg.out_bottom;
    assign result.overhead_total = a_reg.overhead_total;
    assign result.joins_done     = a_reg.joins_done;
    assign result.run_end        = a_reg.run_end;

    // Second slot is only ever filled behind the first
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> a_valid_reg)
        else $error("second result slot holds data while first is empty");

    // No transaction is taken while a second result is still pending
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> !b_valid_reg)
        else $error("transaction taken with no room for its results");

    // A region start clears the abort flag
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && head.first_rect) |=> !aborted_reg)
        else $error("abort flag survived a region start");

    // Join count only drops at a region start
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !head.first_rect) |=> (cnt_reg >= $past(cnt_reg)))
        else $error("join count decreased inside a region");

endmodule

// ===== tb/rjf_join_check.sv =====
`timescale 1ns / 1ps

// Watches the rectangle, result and APB ports, predicts the results of each
// accepted rectangle and compares them in order with what the block emits.
module rjf_join_check (
    input  logic                           clk,
    input  logic                           rst_n,
    rjf_in_if                              rect,
    rjf_out_if                             result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [rjf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rjf_pkg::CFG_DATA_W-1:0] pwdata,
    output int                             fail_count,
    output int                             pending
);
    localparam int CW = rjf_pkg::COORD_W;
    localparam longint SUM_CAP = (longint'(1) << rjf_pkg::SUM_W) - 1;
    localparam int unsigned COUNT_CAP = (1 << rjf_pkg::COUNT_W) - 1;

    // Shadow of the threshold register and of the block's region state
    longint      join_thr = 0;
    longint      prv_l = 0;
    longint      prv_t = 0;
    longint      prv_r = 0;
    longint      prv_b = 0;
    longint      overhead_acc = 0;
    int unsigned join_tally = 0;
    bit          region_dead = 1'b0;

    rjf_pkg::result_t expected_q[$];

    function automatic rjf_pkg::result_t make_result(rjf_pkg::kind_t k, longint l,
                                                     longint t, longint r, longint b,
                                                     longint s, int unsigned c);
        rjf_pkg::result_t res;
        res.kind = k;
        res.out_left = l[CW-1:0];
        res.out_top = t[CW-1:0];
        res.out_right = r[CW-1:0];
        res.out_bottom = b[CW-1:0];
        res.overhead_total = s[rjf_pkg::SUM_W-1:0];
        res.joins_done = c[rjf_pkg::COUNT_W-1:0];
        res.run_end = 1'b0;
        return res;
    endfunction

    // Saturating totals of one region
    function automatic void add_join(longint overhead);
        longint s;
        s = overhead_acc + overhead;
        if (s < 0)
            s = 0;
        if (s > SUM_CAP)
            s = SUM_CAP;
        overhead_acc = s;
        if (join_tally < COUNT_CAP)
            join_tally++;
    endfunction

    // Works out the results of one rectangle and queues them
    function automatic void predict_rect(logic [CW-1:0] il, logic [CW-1:0] it,
                                         logic [CW-1:0] ir, logic [CW-1:0] ib,
                                         logic first, logic last);
        longint  l, t, r, b;
        longint  a_prev, a_new, bl, bt, br, bb, overhead;
        rjf_pkg::result_t outs[2];
        int      n;
        l = il;
        t = it;
        r = ir;
        b = ib;
        n = 0;
        if (first)
        begin
            overhead_acc = 0;
            join_tally = 0;
            region_dead = 1'b0;
        end
        else if (region_dead)
            return;
        else if (t == prv_t && b == prv_b)
        begin
            // same band: order check, then the gap as a filler
            if (prv_r > l)
            begin
                region_dead = 1'b1;
                outs[0] = make_result(rjf_pkg::KIND_ORDER_ERR, 0, 0, 0, 0, 0, 0);
                outs[0].run_end = 1'b1;
                expected_q.push_back(outs[0]);
                return;
            end
            overhead = (l - prv_r) * (b - t);
            if (overhead < join_thr)
            begin
                outs[n] = make_result(rjf_pkg::KIND_FILLER, prv_r, prv_t, l, prv_b, 0, 0);
                n = n + 1;
                add_join(overhead);
            end
        end
        else
        begin
            // other bands: bounding box test, a joined box becomes the previous rectangle
            a_prev = (prv_r - prv_l) * (prv_b - prv_t);
            a_new = (r - l) * (b - t);
            bl = (prv_l < l) ? prv_l : l;
            br = (prv_r > r) ? prv_r : r;
            bt = (prv_t < t) ? prv_t : t;
            bb = (prv_b > b) ? prv_b : b;
            overhead = (br - bl) * (bb - bt) - a_new - a_prev;
            if (overhead < join_thr || overhead < (a_prev + a_new) / rjf_pkg::DIV_CONST)
            begin
                outs[n] = make_result(rjf_pkg::KIND_FILLER, bl, bt, br, bb, 0, 0);
                n = n + 1;
                add_join(overhead);
                l = bl;
                t = bt;
                r = br;
                b = bb;
            end
        end
        prv_l = l;
        prv_t = t;
        prv_r = r;
        prv_b = b;
        if (last)
        begin
            outs[n] = make_result(rjf_pkg::KIND_SUMMARY, 0, 0, 0, 0, overhead_acc,
                                  join_tally);
            n = n + 1;
        end
        if (n > 0)
            outs[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            expected_q.push_back(outs[i]);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        rjf_pkg::result_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready &&
                paddr[rjf_pkg::CFG_ADDR_W-1:2] == rjf_pkg::REG_JOIN_THRESHOLD)
                join_thr = longint'(pwdata[rjf_pkg::THR_W-1:0]);
            if (rect.valid && rect.ready)
                predict_rect(rect.left, rect.top, rect.right, rect.bottom,
                             rect.first_rect, rect.last_rect);
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("kind: expected no transaction, got %0d", result.kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("kind", want.kind, result.kind);
                    check_field("out_left", want.out_left, result.out_left);
                    check_field("out_top", want.out_top, result.out_top);
                    check_field("out_right", want.out_right, result.out_right);
                    check_field("out_bottom", want.out_bottom, result.out_bottom);
                    check_field("overhead_total", want.overhead_total,
                                result.overhead_total);
                    check_field("joins_done", want.joins_done, result.joins_done);
                    check_field("run_end", want.run_end, result.run_end);
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    localparam int CW     = rjf_pkg::COORD_W;
    localparam int TW     = rjf_pkg::THR_W;
    localparam int AW     = rjf_pkg::CFG_ADDR_W;
    localparam int DATA_W = rjf_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [CW-1:0] l;
        logic [CW-1:0] t;
        logic [CW-1:0] r;
        logic [CW-1:0] b;
    } box_t;

    localparam logic [AW-1:0] THR_ADDR = {rjf_pkg::REG_JOIN_THRESHOLD, 2'b00};
    localparam logic [TW-1:0] THR_MAX = '1;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS = 140;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AW-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int useful_sent;

    int idle_tab[4] = '{0, 57, 0, 35};
    int stall_tab[4] = '{0, 0, 57, 35};

    rjf_in_if  rect_ch ();
    rjf_out_if result_ch ();

    rect_join_filler_unit #(
        .COORD_BITS(CW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .rect(rect_ch),
        .result(result_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    rjf_join_check join_check (
        .clk(clk),
        .rst_n(rst_n),
        .rect(rect_ch),
        .result(result_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls, plus a counted hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_rect(input logic [CW-1:0] l, input logic [CW-1:0] t,
                             input logic [CW-1:0] r, input logic [CW-1:0] b,
                             input logic first, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            rect_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        rect_ch.valid <= 1'b1;
        rect_ch.left <= l;
        rect_ch.top <= t;
        rect_ch.right <= r;
        rect_ch.bottom <= b;
        rect_ch.first_rect <= first;
        rect_ch.last_rect <= last;
        do
            @(posedge clk);
        while (!rect_ch.ready);
    endtask

    // Let every expected result come out, then give ignored rectangles time to pass
    task automatic wait_idle();
        rect_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [TW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= THR_ADDR;
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // One region in band order with random content; sometimes without its
    // start or end mark, with one overlap, or with junk rectangles mixed in
    task automatic send_region();
        box_t plan[$];
        box_t nb;
        int   span, y, h, x, w, n_bands, n_cols, bad_idx;
        bit   with_first, with_last, want_overlap;
        span = ($urandom_range(7) == 0) ? 6000 : 40;
        with_first = ($urandom_range(9) != 0);
        with_last = ($urandom_range(9) != 0);
        want_overlap = ($urandom_range(7) == 0);
        bad_idx = 1 << 30;
        y = $urandom_range(0, span);
        n_bands = $urandom_range(1, 4);
        for (int bi = 0; bi < n_bands; bi++)
        begin
            h = $urandom_range(1, span);
            x = $urandom_range(0, span);
            n_cols = $urandom_range(1, 4);
            for (int ci = 0; ci < n_cols; ci++)
            begin
                w = $urandom_range(1, span);
                nb.l = CW'(x);
                nb.t = CW'(y);
                nb.r = CW'(x + w);
                nb.b = CW'(y + h);
                plan.push_back(nb);
                if (want_overlap && ci < n_cols - 1)
                begin
                    x = x + $urandom_range(0, w - 1);
                    bad_idx = plan.size();
                    want_overlap = 1'b0;
                end
                else if ($urandom_range(3) == 0)
                    x = x + w;
                else
                    x = x + w + $urandom_range(1, span);
            end
            if ($urandom_range(1) == 0)
                y = y + h;
            else
                y = y + h + $urandom_range(1, span / 4 + 1);
        end
        for (int i = 0; i < plan.size(); i++)
        begin
            nb = plan[i];
            if ($urandom_range(11) == 0)
                nb = {$urandom, $urandom};
            send_rect(nb.l, nb.t, nb.r, nb.b, with_first && i == 0,
                      with_last && i == plan.size() - 1);
            if (i <= bad_idx)
                useful_sent++;
        end
    endtask

    initial
    begin
        logic [TW-1:0] thr_pick;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rect_ch.valid = 1'b0;
        rect_ch.left = '0;
        rect_ch.top = '0;
        rect_ch.right = '0;
        rect_ch.bottom = '0;
        rect_ch.first_rect = 1'b0;
        rect_ch.last_rect = 1'b0;
        result_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases
        write_threshold(1000);
        send_rect(0, 0, 10, 10, 0, 0);            // no region start after reset
        send_rect(5, 5, 6, 6, 1, 1);              // lone rectangle: summary only
        send_rect(0, 0, 10, 10, 1, 0);
        send_rect(15, 0, 20, 10, 0, 0);           // gap filler
        send_rect(20, 0, 30, 10, 0, 0);           // zero-width gap
        send_rect(100, 0, 200, 10, 0, 1);         // filler and summary together
        send_rect(0, 20, 50, 30, 1, 0);
        send_rect(40, 20, 60, 30, 0, 0);          // overlap in band: order error
        send_rect(70, 20, 80, 30, 0, 0);          // dropped
        send_rect(90, 20, 95, 30, 0, 1);          // dropped, no summary either
        send_rect(0, 10, 5, 5, 1, 0);             // inverted band
        send_rect(20, 10, 30, 5, 0, 0);           // negative overhead, total clamps at zero
        send_rect(40, 30, 10, 20, 0, 1);          // inverted rectangle in another band
        send_rect(0, 0, 65535, 65535, 1, 0);
        send_rect(65535, 65535, 0, 0, 0, 0);
        send_rect(65535, 0, 65535, 65535, 0, 1);
        send_rect(0, 100, 100, 200, 1, 0);
        send_rect(0, 200, 100, 300, 0, 0);        // stacked bands join at no cost
        send_rect(0, 300, 100, 301, 0, 1);
        send_rect(0, 0, 1000, 1000, 1, 0);
        send_rect(0, 1000, 1010, 2000, 0, 1);     // joins on the relative test only
        send_rect(0, 0, 100, 100, 1, 0);
        send_rect(500, 1000, 600, 1100, 0, 1);    // too far apart to join
        send_rect(700, 1100, 800, 1200, 0, 1);    // continues after a region end
        wait_idle();

        // Random regions under several thresholds and idling mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: thr_pick = '0;
                1: thr_pick = TW'($urandom_range(0, 4000));
                2: thr_pick = THR_MAX;
                default: thr_pick = TW'($urandom_range(0, 20000));
            endcase
            write_threshold(thr_pick);
            send_idle_pct = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            if (ph == 2)
                hold_left = 300;
            useful_sent = 0;
            while (useful_sent < PHASE_ITEMS)
            begin
                if ($urandom_range(7) == 0)
                begin
                    send_rect(CW'($urandom_range(65535)), CW'($urandom_range(65535)),
                              CW'($urandom_range(65535)), CW'($urandom_range(65535)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                    useful_sent++;
                end
                else
                    send_region();
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
